>>> sv/cossim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity shared definitions
// Widths, the accumulator record passed from front to back, and limits.
// ----------------------------------------------------------------------------
package cossim_pkg;

  localparam int ELEM_W   = 16;
  localparam int DOT_W    = 42;
  localparam int NORM_W   = 41;
  localparam int ROOT_W   = 21;
  localparam int DEN_W    = 2 * ROOT_W;
  localparam int FRAC_SH  = 14;
  localparam int NUM_W    = DOT_W + FRAC_SH;
  localparam int Q_W      = 15;
  localparam int QUEUE_DEPTH = 4;
  localparam int SIM_MAX  = 16384;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } acc_t;

endpackage

>>> sv/cosine_similarity_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming cosine similarity
// Accumulates dot product and squared norms of two Q2.13 vectors and gives
// one Q1.14 similarity per vector pair.
// ----------------------------------------------------------------------------
//
//  channel  handshake          payload
//  -------  -----------------  --------------------------------------
//  input    in_push / in_full  in_elem_a, in_elem_b, in_last
//  result   out_pop / out_empty out_similarity, out_zero_norm
//
// The front end takes one element pair per cycle while in_full is low: a
// product stage, then a saturating accumulate. A transaction marked last places
// the vector sums in a four-entry queue. The back end takes one vector pair at a
// time: 21 steps of the two bit-pair square roots run side by side, one multiply,
// one range check and 15 restoring division steps, then a load of the output
// register. Short vector pairs fill the queue and raise in_full.
// Reset is synchronous, active low, and clears the sums and all control.
// A stalled result waits in the output register while the back end works on.
// ----------------------------------------------------------------------------
module cosine_similarity_stream (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [cossim_pkg::ELEM_W-1:0] in_elem_a,
  input  logic signed [cossim_pkg::ELEM_W-1:0] in_elem_b,
  input  logic                                 in_last,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [cossim_pkg::ELEM_W-1:0] out_similarity,
  output logic                                 out_zero_norm
);
  import cossim_pkg::*;

  logic accept;
  logic push;
  acc_t push_data;
  logic q_pop;
  logic q_empty;
  logic q_afull;
  acc_t q_head;

  // An input transaction completes when the queue has room to spare.
  assign in_full = q_afull;
  assign accept  = in_push && !q_afull;

  cossim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .elem_a    (in_elem_a),
    .elem_b    (in_elem_b),
    .last      (in_last),
    .push      (push),
    .push_data (push_data)
  );

  cossim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_data   (push_data),
    .pop         (q_pop),
    .empty       (q_empty),
    .almost_full (q_afull),
    .head        (q_head)
  );

  cossim_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_similarity (out_similarity),
    .out_zero_norm  (out_zero_norm)
  );

endmodule

>>> sv/cossim_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity front end
// Registers the element products and accumulates them with saturation.
// ----------------------------------------------------------------------------
module cossim_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic signed [cossim_pkg::ELEM_W-1:0]   elem_a,
  input  logic signed [cossim_pkg::ELEM_W-1:0]   elem_b,
  input  logic                                   last,
  output logic                                   push,
  output cossim_pkg::acc_t                       push_data
);
  import cossim_pkg::*;

  logic                        p_valid_r;
  logic                        p_last_r;
  logic signed [31:0]          p_ab_r;
  logic [30:0]                 p_aa_r;
  logic [30:0]                 p_bb_r;
  logic signed [DOT_W-1:0]     dot_r;
  logic [NORM_W-1:0]           na_r;
  logic [NORM_W-1:0]           nb_r;

  logic signed [31:0]          sq_a;
  logic signed [31:0]          sq_b;
  logic signed [DOT_W:0]       dot_sum;
  logic [NORM_W:0]             na_sum;
  logic [NORM_W:0]             nb_sum;
  acc_t                        acc_nxt;

  assign sq_a = elem_a * elem_a;
  assign sq_b = elem_b * elem_b;

  always_comb begin
    dot_sum = {dot_r[DOT_W-1], dot_r} + {{(DOT_W-31){p_ab_r[31]}}, p_ab_r};
    na_sum  = {1'b0, na_r} + {{(NORM_W-30){1'b0}}, p_aa_r};
    nb_sum  = {1'b0, nb_r} + {{(NORM_W-30){1'b0}}, p_bb_r};
    // Saturate the dot product at the signed limits of its width.
    if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
      acc_nxt.dot = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                   : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      acc_nxt.dot = dot_sum[DOT_W-1:0];
    end
    acc_nxt.norm_a = na_sum[NORM_W] ? {NORM_W{1'b1}} : na_sum[NORM_W-1:0];
    acc_nxt.norm_b = nb_sum[NORM_W] ? {NORM_W{1'b1}} : nb_sum[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      dot_r     <= '0;
      na_r      <= '0;
      nb_r      <= '0;
    end else begin
      p_valid_r <= accept;
      if (p_valid_r) begin
        if (p_last_r) begin
          dot_r <= '0;
          na_r  <= '0;
          nb_r  <= '0;
        end else begin
          dot_r <= acc_nxt.dot;
          na_r  <= acc_nxt.norm_a;
          nb_r  <= acc_nxt.norm_b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_last_r <= last;
      p_ab_r   <= elem_a * elem_b;
      p_aa_r   <= sq_a[30:0];
      p_bb_r   <= sq_b[30:0];
    end
  end

  assign push      = p_valid_r & p_last_r;
  assign push_data = acc_nxt;

endmodule

>>> sv/cossim_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity accumulator queue
// Short FIFO of finished vector sums between front and back.
// ----------------------------------------------------------------------------
module cossim_queue #(
  parameter int DEPTH = cossim_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cossim_pkg::acc_t  push_data,
  input  logic              pop,
  output logic              empty,
  output logic              almost_full,
  output cossim_pkg::acc_t  head
);
  import cossim_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  acc_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign empty = (count_r == '0);
  // One slot stays free for the sum still in the product stage.
  assign almost_full = (count_r >= CNT_W'(DEPTH - 1));
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/cossim_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity back end
// Two square roots, one multiply and a short division, one step a cycle.
// ----------------------------------------------------------------------------
module cossim_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  cossim_pkg::acc_t                     q_head,
  output logic                                 q_pop,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [cossim_pkg::ELEM_W-1:0] out_similarity,
  output logic                                 out_zero_norm
);
  import cossim_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ROOT, S_MUL, S_CHK, S_DIV, S_DONE} state_t;

  state_t             state_r;
  logic [4:0]         step_r;
  logic               neg_r;
  logic               zero_r;
  logic [NORM_W-1:0]  va_r, ra_r, ba_r;
  logic [NORM_W-1:0]  vb_r, rb_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   rem_r;
  logic [NUM_W-1:0]   dsh_r;
  logic [Q_W-1:0]     q_r;
  logic               out_valid_r;
  logic signed [ELEM_W-1:0] sim_r;
  logic               zn_r;

  logic [NORM_W-1:0]  sa, sb;
  logic               ge_a, ge_b;
  logic [DOT_W-1:0]   mag;
  logic [Q_W-1:0]     q_fin;
  logic [ELEM_W-1:0]  sim_fin;
  logic               out_free;

  assign sa   = ra_r + ba_r;
  assign sb   = rb_r + ba_r;
  assign ge_a = (va_r >= sa);
  assign ge_b = (vb_r >= sb);
  assign mag  = q_head.dot[DOT_W-1] ? (~q_head.dot + 1'b1) : q_head.dot;
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    q_fin = (q_r > Q_W'(SIM_MAX)) ? Q_W'(SIM_MAX) : q_r;
    if (zero_r) begin
      sim_fin = '0;
    end else if (neg_r) begin
      sim_fin = -{1'b0, q_fin};
    end else begin
      sim_fin = {1'b0, q_fin};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A result leaving while the next one loads keeps the register full.
      if (out_pop && out_valid_r && !((state_r == S_DONE) && out_free)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            neg_r  <= q_head.dot[DOT_W-1];
            rem_r  <= {mag, {FRAC_SH{1'b0}}};
            va_r   <= q_head.norm_a;
            vb_r   <= q_head.norm_b;
            ra_r   <= '0;
            rb_r   <= '0;
            ba_r   <= {1'b1, {(NORM_W-1){1'b0}}};
            step_r <= 5'(ROOT_W - 1);
            zero_r <= (q_head.norm_a == '0) || (q_head.norm_b == '0);
            q_r    <= '0;
            state_r <= ((q_head.norm_a == '0) || (q_head.norm_b == '0))
                       ? S_DONE : S_ROOT;
          end
        end
        S_ROOT: begin
          if (ge_a) begin
            va_r <= va_r - sa;
            ra_r <= (ra_r >> 1) + ba_r;
          end else begin
            ra_r <= ra_r >> 1;
          end
          if (ge_b) begin
            vb_r <= vb_r - sb;
            rb_r <= (rb_r >> 1) + ba_r;
          end else begin
            rb_r <= rb_r >> 1;
          end
          ba_r <= ba_r >> 2;
          if (step_r == '0) begin
            state_r <= S_MUL;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_MUL: begin
          den_r   <= ra_r[ROOT_W-1:0] * rb_r[ROOT_W-1:0];
          state_r <= S_CHK;
        end
        S_CHK: begin
          // A quotient of 2^15 or more clamps straight away.
          if ({1'b0, rem_r} >= {den_r, {(Q_W){1'b0}}}) begin
            q_r     <= {Q_W{1'b1}};
            state_r <= S_DONE;
          end else begin
            dsh_r   <= {den_r, {(Q_W-1){1'b0}}};
            step_r  <= 5'(Q_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[Q_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[Q_W-2:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          if (step_r == '0) begin
            state_r <= S_DONE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            sim_r       <= sim_fin;
            zn_r        <= zero_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_similarity = sim_r;
  assign out_zero_norm  = zn_r;

endmodule

>>> tb/sv/tb_cosine_similarity_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity stream testbench
// Streams element pairs through the block, predicts every similarity with a
// behavioral model of the accumulators, roots and divide, and checks each
// result transaction against the oldest prediction, under random idling.
// ----------------------------------------------------------------------------
module tb_cosine_similarity_stream;
  import cossim_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     last;
  } pair_t;

  typedef struct {
    logic signed [ELEM_W-1:0] sim;
    logic                     zn;
  } sim_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic signed [ELEM_W-1:0] in_elem_a;
  logic signed [ELEM_W-1:0] in_elem_b;
  logic in_last;
  logic out_pop;
  logic out_empty;
  logic signed [ELEM_W-1:0] out_similarity;
  logic out_zero_norm;

  cosine_similarity_stream DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_last(in_last),
    .out_pop(out_pop), .out_empty(out_empty),
    .out_similarity(out_similarity), .out_zero_norm(out_zero_norm)
  );

  // Pending input pairs and the similarities they are expected to produce.
  pair_t pair_q[$];
  sim_t  sim_q[$];

  // Predictor state: the three running sums.
  logic signed [63:0] dot_sum;
  logic [63:0]        na_sum;
  logic [63:0]        nb_sum;

  int  errors = 0;
  int  cycles = 0;
  int  vectors_seen = 0;
  int  send_idle_pct = 11;
  int  recv_idle_pct = 64;
  int  hold_cycles = 0;
  bit  hold_off;
  bit  stim_done = 0;

  assign hold_off = (hold_cycles != 0);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Adds one accepted pair to the sums; on the last pair it queues the result.
  task automatic accumulate_pair(pair_t p);
    logic signed [63:0] d;
    logic [63:0] s;
    logic [63:0] ra;
    logic [63:0] rb;
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [63:0] dmax;
    logic [63:0] nmax;
    sim_t r;
    dmax = (64'sd1 <<< 41) - 1;
    nmax = (64'd1 << 41) - 1;
    d = dot_sum + 64'(p.a) * 64'(p.b);
    if (d > dmax) d = dmax;
    if (d < -dmax - 1) d = -dmax - 1;
    dot_sum = d;
    s = na_sum + 64'(64'(p.a) * 64'(p.a));
    na_sum = (s > nmax) ? nmax : s;
    s = nb_sum + 64'(64'(p.b) * 64'(p.b));
    nb_sum = (s > nmax) ? nmax : s;
    if (!p.last) return;
    if (na_sum == 0 || nb_sum == 0) begin
      r.sim = '0;
      r.zn = 1'b1;
    end else begin
      ra = floor_root(na_sum);
      rb = floor_root(nb_sum);
      mag = (dot_sum < 0) ? -dot_sum : dot_sum;
      q = (mag << 14) / (ra * rb);
      if (q > SIM_MAX) q = SIM_MAX;
      r.sim = (dot_sum < 0) ? -q[15:0] : q[15:0];
      r.zn = 1'b0;
    end
    sim_q.push_back(r);
    dot_sum = 0;
    na_sum = 0;
    nb_sum = 0;
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_pair(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b, logic l);
    pair_t p;
    p.a = a;
    p.b = b;
    p.last = l;
    pair_q.push_back(p);
  endtask

  task automatic push_vector(int len, int kind);
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = rand_elem();
      // Correlated, anti-correlated, independent or zero second vector.
      case (kind)
        0: b = a;
        1: b = -a;
        2: b = rand_elem();
        default: b = '0;
      endcase
      push_pair(a, b, i == len - 1);
    end
  endtask

  // Decides whether a new pair is offered this cycle; an accepted pair has
  // already left the pending queue when this is called.
  function automatic bit in_push_next();
    int avail;
    avail = pair_q.size();
    if (avail <= 0) return 0;
    return $urandom_range(0, 99) >= send_idle_pct;
  endfunction

  // Driver: offers the head of the pending queue, holding it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        void'(pair_q.pop_front());
      end
      if (((in_push && !in_full) || !in_push) && in_push_next()) begin
        in_push   <= 1'b1;
        in_elem_a <= pair_q[0].a;
        in_elem_b <= pair_q[0].b;
        in_last   <= pair_q[0].last;
      end else if ((in_push && !in_full) || !in_push) begin
        in_push <= 1'b0;
      end
    end
  end

  // Accepted pairs feed the predictor on the same edge.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      pair_t p;
      p.a = in_elem_a;
      p.b = in_elem_b;
      p.last = in_last;
      accumulate_pair(p);
    end
  end

  // Receiver hold-off, counted down one cycle at a time.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: checks each popped result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        vectors_seen++;
        if (sim_q.size() == 0) begin
          $display("%0t: unexpected result sim=%0d zn=%0b", $time, out_similarity,
                   out_zero_norm);
          errors++;
        end else begin
          sim_t e;
          e = sim_q.pop_front();
          if (out_similarity !== e.sim) begin
            $display("%0t: similarity expected %0d actual %0d", $time, e.sim,
                     out_similarity);
            errors++;
          end
          if (out_zero_norm !== e.zn) begin
            $display("%0t: zero_norm expected %0b actual %0b", $time, e.zn,
                     out_zero_norm);
            errors++;
          end
        end
      end
      out_pop <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pair_q.size() != 0 || in_push || sim_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_push = 0;
    in_elem_a = '0;
    in_elem_b = '0;
    in_last = 0;
    out_pop = 0;
    dot_sum = 0;
    na_sum = 0;
    nb_sum = 0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, single-element vectors, zero norms, clamping.
    push_pair(16'h7fff, 16'h7fff, 1);
    push_pair(16'h8000, 16'h8000, 1);
    push_pair(16'h8000, 16'h7fff, 1);
    push_pair(16'h0000, 16'h1234, 1);
    push_pair(16'h4321, 16'h0000, 1);
    push_pair(16'h0000, 16'h0000, 1);
    push_pair(16'h0001, 16'hffff, 1);
    push_pair(16'h0003, 16'h0001, 0);
    push_pair(16'h0001, 16'h0003, 1);
    push_pair(16'h2000, 16'h0000, 0);
    push_pair(16'h0000, 16'h2000, 1);
    push_pair(16'h5555, 16'haaaa, 0);
    push_pair(16'h0007, 16'h0005, 1);
    wait_drained();

    // Long vectors of maximal pairs build large sums and wide roots.
    for (int i = 0; i < 200; i++) push_pair(16'h8000, 16'h8000, i == 199);
    for (int i = 0; i < 100; i++) push_pair(16'h8000, 16'h7fff, i == 99);
    wait_drained();

    // Long receiver hold-off while short vectors fill the block.
    hold_cycles = 600;
    for (int i = 0; i < 30; i++) push_vector($urandom_range(1, 3), $urandom_range(0, 3));
    wait (hold_cycles == 0);
    wait_drained();

    // Random phases with the three idling profiles.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 11 : 0;
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 19) == 0) push_vector($urandom_range(20, 60), $urandom_range(0, 3));
        else push_vector($urandom_range(1, 4), $urandom_range(0, 3));
      end
      wait_drained();
    end
    stim_done = 1;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered extremes, zero norms, long maximal vectors, a long output stall and");
    $display("%0d vector results under three idling profiles.", vectors_seen);
    if (errors == 0 && sim_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> cosine_similarity_stream.f
sv/cossim_pkg.sv
sv/cossim_front.sv
sv/cossim_queue.sv
sv/cossim_back.sv
sv/cosine_similarity_stream.sv
tb/sv/tb_cosine_similarity_stream.sv
